>>> src/rsg_pkg.sv
// Package for the replacement-selection run generator.
// Holds sizes, payload structs, the cell control bundle and the sequencer states.
// No dependencies.
package rsg_pkg;

    localparam int TREE_LEVELS = 2;
    localparam int LEAVES      = 1 << TREE_LEVELS;
    localparam int IDX_W       = (TREE_LEVELS > 0) ? TREE_LEVELS : 1;
    localparam int CNT_W       = TREE_LEVELS + 1;
    localparam int VAL_W       = 16;

    typedef struct packed {
        logic [VAL_W-1:0] record_value;
        logic             end_of_data;
    } rsg_in_t;

    typedef struct packed {
        logic [VAL_W-1:0] out_value;
        logic             run_end;
        logic             last_of_burst;
    } rsg_out_t;

    // Running selection handed from cell to cell along the row
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] idx;
    } rsg_best_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             load;
        logic             kill;
        logic             freeze;
        logic             thaw;
        logic             wipe;
        logic [IDX_W-1:0] sel_idx;
        logic [VAL_W-1:0] rec_value;
        logic [VAL_W-1:0] last_value;
        logic             run_open;
    } rsg_cell_ctl_t;

    typedef enum logic [1:0] {
        RSG_IDLE,
        RSG_PICK,
        RSG_DRAIN
    } rsg_state_t;

endpackage

>>> src/replacement_selection_run_generator.sv
// Top level of the replacement-selection run generator.
// Depends on rsg_pkg and rsg_cell.
//
// Usage:
//   s_ channel takes one record transaction {record_value, end_of_data}.
//   m_ channel gives result transactions {out_value, run_end, last_of_burst}.
//   The first LEAVES records only fill the row of cells and give no result.
//   Each later record emits the smallest live entry above the last output
//   (or any entry at the start of a run) and takes that entry's cell; all
//   entries that cannot extend the run are frozen in the same cycle. When
//   every entry is frozen, all thaw and a run-end marker (value zero) is sent.
//   A record with end_of_data set is placed first, then the whole store is
//   drained in sorted runs, closed by a final run-end marker; the block is
//   then back in its reset state.
// Timing: a fill record is written into its cell as it is accepted; a
//   replacement is accepted, then takes one selection step through the cell
//   row; a run-end marker takes a step of its own. A drain emits one result
//   per cycle unless stalled; its last step sends the final run-end marker
//   and empties the store. Each selection step ripples through the LEAVES cells.
// Reset: aresetn low for one edge empties the store and clears the run.
// Stall: results sit in one output register; while it is full and m_ready is
//   low the sequencer holds, and s_ready stays low until the record is done.
module replacement_selection_run_generator (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rsg_pkg::rsg_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rsg_pkg::rsg_out_t m_data
);
    import rsg_pkg::*;

    rsg_state_t       state_reg, state_next;
    logic [VAL_W-1:0] rec_reg, rec_next;
    logic             eod_reg, eod_next;
    logic [CNT_W-1:0] fill_count_reg, fill_next;
    logic [VAL_W-1:0] last_emitted_reg, last_next;
    logic             run_open_reg, run_open_next;
    rsg_out_t         m_data_reg;
    logic             m_valid_reg;

    rsg_cell_ctl_t    ctl;
    rsg_best_t        best [LEAVES+1];
    logic [LEAVES-1:0] live_vec;
    logic             fill_full;
    logic             step_ok;
    logic             any_live;
    logic             emit;
    rsg_out_t         emit_data;

    // Row of cells; the running minimum ripples from cell 0 upward
    assign best[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < LEAVES; gi++) begin : g_cell
            rsg_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (IDX_W'(gi)),
                .ctl      (ctl),
                .best_in  (best[gi]),
                .best_out (best[gi+1]),
                .live_out (live_vec[gi])
            );
        end
    endgenerate

    assign fill_full = (fill_count_reg >= CNT_W'(LEAVES));
    assign step_ok   = !m_valid_reg || m_ready;
    assign any_live  = |live_vec;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            RSG_IDLE: begin
                if (s_valid) begin
                    if (!fill_full) begin
                        state_next = s_data.end_of_data ? RSG_DRAIN : RSG_IDLE;
                    end else begin
                        state_next = RSG_PICK;
                    end
                end
            end
            RSG_PICK: begin
                if (step_ok && best[LEAVES].found) begin
                    state_next = eod_reg ? RSG_DRAIN : RSG_IDLE;
                end
            end
            RSG_DRAIN: begin
                if (step_ok && !best[LEAVES].found && !any_live) begin
                    state_next = RSG_IDLE;
                end
            end
            default: state_next = RSG_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb begin
        ctl            = '0;
        ctl.rec_value  = rec_reg;
        ctl.last_value = last_emitted_reg;
        ctl.run_open   = run_open_reg;
        s_ready        = (state_reg == RSG_IDLE);
        emit           = 1'b0;
        emit_data      = '0;
        rec_next       = rec_reg;
        eod_next       = eod_reg;
        fill_next      = fill_count_reg;
        last_next      = last_emitted_reg;
        run_open_next  = run_open_reg;
        case (state_reg)
            RSG_IDLE: begin
                if (s_valid) begin
                    rec_next = s_data.record_value;
                    eod_next = s_data.end_of_data;
                    if (!fill_full) begin
                        // fill phase: drop the record straight into the next cell
                        ctl.load      = 1'b1;
                        ctl.sel_idx   = fill_count_reg[IDX_W-1:0];
                        ctl.rec_value = s_data.record_value;
                        fill_next     = fill_count_reg + CNT_W'(1);
                    end
                end
            end
            RSG_PICK: begin
                if (step_ok) begin
                    if (best[LEAVES].found) begin
                        // emit the winner and put the new record in its cell
                        emit                    = 1'b1;
                        emit_data.out_value     = best[LEAVES].value;
                        emit_data.last_of_burst = !eod_reg;
                        ctl.freeze              = 1'b1;
                        ctl.load                = 1'b1;
                        ctl.sel_idx             = best[LEAVES].idx;
                        last_next               = best[LEAVES].value;
                        run_open_next           = 1'b1;
                    end else begin
                        // everything frozen: close the run and thaw
                        emit              = 1'b1;
                        emit_data.run_end = 1'b1;
                        ctl.thaw          = 1'b1;
                        last_next         = '0;
                        run_open_next     = 1'b0;
                    end
                end
            end
            RSG_DRAIN: begin
                if (step_ok) begin
                    if (best[LEAVES].found) begin
                        emit                = 1'b1;
                        emit_data.out_value = best[LEAVES].value;
                        ctl.freeze          = 1'b1;
                        ctl.kill            = 1'b1;
                        ctl.sel_idx         = best[LEAVES].idx;
                        last_next           = best[LEAVES].value;
                        run_open_next       = 1'b1;
                    end else if (any_live) begin
                        emit              = 1'b1;
                        emit_data.run_end = 1'b1;
                        ctl.thaw          = 1'b1;
                        last_next         = '0;
                        run_open_next     = 1'b0;
                    end else begin
                        // store empty: close the last run and return to reset state
                        if (run_open_reg) begin
                            emit                    = 1'b1;
                            emit_data.run_end       = 1'b1;
                            emit_data.last_of_burst = 1'b1;
                        end
                        ctl.wipe      = 1'b1;
                        fill_next     = '0;
                        last_next     = '0;
                        run_open_next = 1'b0;
                    end
                end
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
        eod_reg <= eod_next;
        if (emit) begin
            m_data_reg <= emit_data;
        end
        if (!aresetn) begin
            state_reg        <= RSG_IDLE;
            fill_count_reg   <= '0;
            last_emitted_reg <= '0;
            run_open_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            fill_count_reg   <= fill_next;
            last_emitted_reg <= last_next;
            run_open_reg     <= run_open_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A result is produced only when the output register can take it
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_ready))
        else $error("result produced while output register is occupied");

    // Replacement only happens with a full store
    a_pick_store_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RSG_PICK) |-> (fill_full && (&live_vec)))
        else $error("replacement step with a partly filled store");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_W'(LEAVES))
        else $error("fill count beyond store size");

    // Closing a drain leaves the block as after reset
    a_drain_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.wipe |=> (fill_count_reg == '0 && live_vec == '0 && !run_open_reg
                      && state_reg == RSG_IDLE))
        else $error("drain did not return the block to its reset state");

    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.run_end) |-> (m_data_reg.out_value == '0))
        else $error("run-end marker carries a nonzero value");

endmodule

>>> src/rsg_cell.sv
// One store cell: a record, its frozen bit and its live bit.
// Takes the running minimum from its left neighbor and hands it on.
// Depends on rsg_pkg.
module rsg_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [rsg_pkg::IDX_W-1:0] cell_idx,
    input  rsg_pkg::rsg_cell_ctl_t ctl,
    input  rsg_pkg::rsg_best_t    best_in,
    output rsg_pkg::rsg_best_t    best_out,
    output logic                  live_out
);
    import rsg_pkg::*;

    logic [VAL_W-1:0] value_reg, value_next;
    logic             frozen_reg, frozen_next;
    logic             live_reg, live_next;
    logic             cand;
    logic             take;
    logic             sel;

    always_comb begin
        cand = live_reg && !frozen_reg && (!ctl.run_open || (value_reg > ctl.last_value));
        take = cand && (!best_in.found || (value_reg < best_in.value));
        sel  = (cell_idx == ctl.sel_idx);
        if (take) begin
            best_out.found = 1'b1;
            best_out.value = value_reg;
            best_out.idx   = cell_idx;
        end else begin
            best_out = best_in;
        end
    end

    always_comb begin
        value_next  = value_reg;
        frozen_next = frozen_reg;
        live_next   = live_reg;
        if (ctl.wipe) begin
            live_next   = 1'b0;
            frozen_next = 1'b0;
        end
        if (ctl.thaw) begin
            frozen_next = 1'b0;
        end
        // freeze every live entry that cannot extend the current run
        if (ctl.freeze && live_reg && !frozen_reg && !cand) begin
            frozen_next = 1'b1;
        end
        if (ctl.load && sel) begin
            value_next  = ctl.rec_value;
            frozen_next = 1'b0;
            live_next   = 1'b1;
        end
        if (ctl.kill && sel) begin
            live_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (!aresetn) begin
            frozen_reg <= 1'b0;
            live_reg   <= 1'b0;
        end else begin
            frozen_reg <= frozen_next;
            live_reg   <= live_next;
        end
    end

    assign live_out = live_reg;

endmodule

>>> tb/sv/tb.sv
// Testbench for replacement_selection_run_generator: directed and random record streams.
// Checks each result transaction against a built-in replacement-selection predictor.
// Depends on rsg_pkg and the block's RTL.
module tb;
    import rsg_pkg::*;

    // Generous cycle budget: ~500 records, up to 11 results each, random
    // receiver stalls, plus one long receiver hold-off.
    localparam int CYCLE_LIMIT = 300000;
    // Settle time after the last expected result; a fill record gives no
    // result but still has to be written into its cell.
    localparam int TAIL_CYCLES = 16;
    localparam int HOLD_CYCLES = 400;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rsg_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rsg_out_t m_data;

    // Pacing controls; all but rx_draw are written with nonblocking assignments at clock edges
    bit gaps_on = 1'b1;
    bit rx_hold = 1'b0;
    int rx_wait = 0;
    int rx_draw;

    int cycle_count = 0;
    int fail_count  = 0;

    // Results still owed by the block, oldest first
    rsg_out_t emitted_queue[$];

    // Predictor copy of the store
    logic [VAL_W-1:0] store_value  [LEAVES];
    bit               store_frozen [LEAVES];
    logic [VAL_W-1:0] last_out;
    bit               run_live;
    int               fill_n;

    always #4 aclk = ~aclk;

    replacement_selection_run_generator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_store();
        for (int i = 0; i < LEAVES; i++) begin
            store_value[i]  = '0;
            store_frozen[i] = 1'b0;
        end
        last_out = '0;
        run_live = 1'b0;
        fill_n   = 0;
    endfunction

    function automatic void owe_result(logic [VAL_W-1:0] value, logic marker);
        rsg_out_t r;
        r.out_value     = value;
        r.run_end       = marker;
        r.last_of_burst = 1'b0;
        emitted_queue.push_back(r);
    endfunction

    // Emit the smallest live entry among mask that extends the current run.
    // Freeze entries that cannot extend it; when everything in mask is frozen,
    // thaw the whole store and close the run with a marker. Return the slot
    // emitted, or -1 when mask is empty.
    function automatic int select_entry(logic [LEAVES-1:0] mask);
        int best;
        while (1'b1) begin
            best = -1;
            for (int s = 0; s < LEAVES; s++) begin
                if (mask[s] && !store_frozen[s]) begin
                    // strict less-than keeps the lowest slot on ties
                    if (best < 0 || store_value[s] < store_value[best])
                        best = s;
                end
            end
            if (best >= 0) begin
                if (!run_live || store_value[best] > last_out) begin
                    owe_result(store_value[best], 1'b0);
                    last_out = store_value[best];
                    run_live = 1'b1;
                    return best;
                end
                // equal to or below the last output: hold it for the next run
                store_frozen[best] = 1'b1;
            end else begin
                if (mask == '0)
                    return -1;
                for (int s = 0; s < LEAVES; s++)
                    store_frozen[s] = 1'b0;
                owe_result('0, 1'b1);
                run_live = 1'b0;
                last_out = '0;
            end
        end
        return -1;
    endfunction

    // Work out every result one accepted record causes
    function automatic void predict_record(rsg_in_t item);
        int               slot;
        int               start_size;
        logic [LEAVES-1:0] live_mask;
        rsg_out_t         tail;
        start_size = emitted_queue.size();
        if (fill_n < LEAVES) begin
            store_value[fill_n]  = item.record_value;
            store_frozen[fill_n] = 1'b0;
            fill_n++;
            live_mask = LEAVES'((1 << fill_n) - 1);
        end else begin
            slot = select_entry('1);
            if (slot >= 0) begin
                store_value[slot]  = item.record_value;
                store_frozen[slot] = 1'b0;
            end
            live_mask = '1;
        end
        if (item.end_of_data) begin
            // drain only the entries written so far
            do begin
                slot = select_entry(live_mask);
                if (slot >= 0)
                    live_mask[slot] = 1'b0;
            end while (slot >= 0);
            if (run_live)
                owe_result('0, 1'b1);
            clear_store();
        end
        if (emitted_queue.size() > start_size) begin
            tail = emitted_queue.pop_back();
            tail.last_of_burst = 1'b1;
            emitted_queue.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitors and checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    endtask

    // Predict on every accepted record transaction
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            predict_record(s_data);
    end

    // Compare every accepted result transaction with the oldest expectation
    always @(posedge aclk) begin
        rsg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (emitted_queue.size() == 0) begin
                report_mismatch("result with nothing owed, out_value", m_data.out_value, 0);
            end else begin
                want = emitted_queue.pop_front();
                if (m_data.out_value !== want.out_value)
                    report_mismatch("out_value", m_data.out_value, want.out_value);
                if (m_data.run_end !== want.run_end)
                    report_mismatch("run_end", m_data.run_end, want.run_end);
                if (m_data.last_of_burst !== want.last_of_burst)
                    report_mismatch("last_of_burst", m_data.last_of_burst, want.last_of_burst);
            end
        end
    end

    // Receiver pacing: after each accepted result, ready may drop for a random rx_wait countdown.
    // A hold-off forces ready low for as long as rx_hold stays set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (rx_hold) begin
            m_ready <= 1'b0;
        end else if (m_ready) begin
            if (m_valid) begin
                rx_draw = gaps_on ? $urandom_range(3) : 0;
                m_ready <= (rx_draw == 0);
                rx_wait <= rx_draw;
            end
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[replacement_selection_run_generator] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one record and return at the edge that accepts it. Valid is
    // left high so a back-to-back record needs no second assignment in the
    // same step; pause_sender lowers it when the stream stops.
    task automatic send_record(logic [VAL_W-1:0] value, logic eod);
        int gap;
        gap = gaps_on ? $urandom_range(3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_data.record_value <= value;
        s_data.end_of_data  <= eod;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender();
        s_valid <= 1'b0;
    endtask

    // Stop offering, then wait until every owed result is back and the
    // block has had time to finish any fill record.
    task automatic wait_quiet();
        pause_sender();
        @(posedge aclk);
        while (emitted_queue.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // End of data on the very first record, then during a partial fill
    task automatic test_drain_during_fill();
        send_record(16'hABCD, 1'b1);
        send_record(16'd5, 1'b0);
        send_record(16'd3, 1'b0);
        send_record(16'd9, 1'b1);
        wait_quiet();
    endtask

    // Field extremes, alternating so the first output of a run takes zero
    task automatic test_value_extremes();
        send_record(16'h0000, 1'b0);
        send_record(16'hFFFF, 1'b0);
        send_record(16'h0000, 1'b0);
        send_record(16'hFFFF, 1'b0);
        send_record(16'h0000, 1'b0);
        send_record(16'hFFFF, 1'b1);
        wait_quiet();
    endtask

    // Duplicates: ties pick the lowest slot, equal-to-last entries freeze
    task automatic test_ties_and_freeze();
        repeat (6) send_record(16'd10, 1'b0);
        send_record(16'd5, 1'b0);
        send_record(16'd20, 1'b1);
        wait_quiet();
    endtask

    // Falling values freeze the whole store and force run-end markers
    task automatic test_falling_runs();
        send_record(16'd40, 1'b0);
        send_record(16'd30, 1'b0);
        send_record(16'd20, 1'b0);
        send_record(16'd10, 1'b0);
        send_record(16'd5, 1'b0);
        send_record(16'd3, 1'b0);
        send_record(16'd1, 1'b0);
        send_record(16'd0, 1'b1);
        wait_quiet();
    endtask

    // Hold the receiver off while records keep coming, so the output
    // register fills and the block stalls its input
    task automatic test_receiver_holdoff();
        rx_hold <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++)
            send_record(16'($urandom), (i == 19) || (i == 39));
        wait_quiet();
    endtask

    // Mostly complete record streams closed by end of data, with random
    // content; some end early, some never close, some carry a stray end flag
    task automatic test_random_runs(int target);
        int               sent;
        int               seq_len;
        int               mode;
        int               trend;
        bit               open_end;
        logic [VAL_W-1:0] value;
        logic             eod;
        sent = 0;
        while (sent < target) begin
            gaps_on  <= ($urandom_range(4) != 0);
            seq_len  = ($urandom_range(9) == 0) ? $urandom_range(1, LEAVES)
                                               : $urandom_range(LEAVES + 1, 40);
            mode     = $urandom_range(3);
            open_end = ($urandom_range(9) == 0);
            for (int pos = 0; pos < seq_len; pos++) begin
                case (mode)
                    0: value = 16'($urandom);
                    1: value = 16'($urandom_range(7));            // many ties
                    2: value = $urandom_range(1) ? 16'($urandom_range(3))
                                                 : 16'hFFFF - 16'($urandom_range(3));
                    default: begin                                 // falling trend
                        trend = 60000 - pos * 1200 + $urandom_range(2000);
                        value = trend[VAL_W-1:0];
                    end
                endcase
                eod = ((pos == seq_len - 1) && !open_end) || ($urandom_range(49) == 0);
                send_record(value, eod);
                sent++;
            end
        end
        wait_quiet();
        gaps_on <= 1'b1;
    endtask

    initial begin
        clear_store();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_drain_during_fill();
        test_value_extremes();
        test_ties_and_freeze();
        test_falling_runs();
        test_receiver_holdoff();
        test_random_runs(420);

        if (fail_count == 0) begin
            $display("[replacement_selection_run_generator] OK");
        end else begin
            $display("[replacement_selection_run_generator] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
src/rsg_pkg.sv
src/rsg_cell.sv
src/replacement_selection_run_generator.sv
tb/sv/tb.sv
